[sv/tsrp_pkg.sv]
// Shared constants, register indexes, area codes and the command/status
// structs of the tilemap scroll refill planner.
// No dependencies.
package tsrp_pkg;

	localparam int MAX_MAP_TILES_DEF = 1024;
	localparam int RING_SIZE         = 32;
	localparam int SPAN_COLS         = 30;
	localparam int SPAN_ROWS         = 20;
	localparam int OVERLAP_LIMIT     = SPAN_COLS * SPAN_ROWS / 4;
	localparam int TILE_SHIFT        = 3;

	localparam int PX_W       = 16;
	localparam int TILE_W     = PX_W - TILE_SHIFT;
	localparam int COORD_W    = TILE_W + 1;
	localparam int SIZE_CFG_W = 11;
	localparam int VIEW_W     = 10;
	localparam int WORLD_W    = 10;
	localparam int RING_W     = $clog2(RING_SIZE);
	localparam int LEN_W      = 5;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;

	localparam logic [2:0] REG_MAP_WIDTH   = 3'd0;
	localparam logic [2:0] REG_MAP_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_WRAP_ENABLE = 3'd2;
	localparam logic [2:0] REG_VIEW_WIDTH  = 3'd3;
	localparam logic [2:0] REG_VIEW_HEIGHT = 3'd4;

	localparam logic [1:0] AREA_FULL = 2'd0;
	localparam logic [1:0] AREA_HORZ = 2'd1;
	localparam logic [1:0] AREA_VERT = 2'd2;

	typedef struct packed {
		logic       load;
		logic       clear_prev;
		logic       plan;
		logic       area_start;
		logic [1:0] area;
		logic       take_mod;
		logic       emit;
		logic       emit_none;
		logic       last;
	} tsrp_cmd_t;

	typedef struct packed {
		logic nochange;
		logic full;
		logic hor_strip;
		logic ver_strip;
		logic mods_done;
		logic rows_last;
		logic out_free;
	} tsrp_stat_t;

endpackage

[sv/tilemap_scroll_refill_planner_core.sv]
// Tilemap scroll refill planner: APB register file, controller and datapath.
// A scroll word passes plan, decide, area setup and the modulo units before
// its first span, then gives one span per cycle while the output is not stalled.
// A reset word only clears the previous tile. Throughput is set by modulo
// waits and spans.
// Async reset clears config to defaults and previous tile to -1.
module tilemap_scroll_refill_planner_core import tsrp_pkg::*; #(
	parameter int MaxMapTiles = MAX_MAP_TILES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic signed [PX_W-1:0] view_x_px,
	input  logic signed [PX_W-1:0] view_y_px,
	input  logic                   force_refill,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [RING_W-1:0]      map_row,
	output logic [RING_W-1:0]      map_col_start,
	output logic [WORLD_W-1:0]     world_x_start,
	output logic [WORLD_W-1:0]     world_row,
	output logic [LEN_W-1:0]       span_length,
	output logic signed [PX_W-1:0] scroll_x,
	output logic signed [PX_W-1:0] scroll_y,
	output logic                   last
);

	logic [SIZE_CFG_W-1:0] map_width_q;
	logic [SIZE_CFG_W-1:0] map_height_q;
	logic                  wrap_q;
	logic [VIEW_W-1:0]     view_width_q;
	logic [VIEW_W-1:0]     view_height_q;
	logic [2:0]            reg_idx;
	logic                  wr_en;

	tsrp_cmd_t  cmd;
	tsrp_stat_t stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= SIZE_CFG_W'(64);
			map_height_q  <= SIZE_CFG_W'(64);
			wrap_q        <= 1'b0;
			view_width_q  <= VIEW_W'(240);
			view_height_q <= VIEW_W'(160);
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAP_WIDTH:   map_width_q   <= pwdata[SIZE_CFG_W-1:0];
				REG_MAP_HEIGHT:  map_height_q  <= pwdata[SIZE_CFG_W-1:0];
				REG_WRAP_ENABLE: wrap_q        <= pwdata[0];
				REG_VIEW_WIDTH:  view_width_q  <= pwdata[VIEW_W-1:0];
				REG_VIEW_HEIGHT: view_height_q <= pwdata[VIEW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAP_WIDTH:   prdata = PDATA_W'(map_width_q);
			REG_MAP_HEIGHT:  prdata = PDATA_W'(map_height_q);
			REG_WRAP_ENABLE: prdata = PDATA_W'(wrap_q);
			REG_VIEW_WIDTH:  prdata = PDATA_W'(view_width_q);
			REG_VIEW_HEIGHT: prdata = PDATA_W'(view_height_q);
			default:         prdata = '0;
		endcase
	end

	tsrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tsrp_datapath #(.MaxMapTiles(MaxMapTiles)) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.map_width_tiles  (map_width_q),
		.map_height_tiles (map_height_q),
		.wrap_enable      (wrap_q),
		.view_width_px    (view_width_q),
		.view_height_px   (view_height_q),
		.view_x_px        (view_x_px),
		.view_y_px        (view_y_px),
		.force_refill     (force_refill),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.map_row          (map_row),
		.map_col_start    (map_col_start),
		.world_x_start    (world_x_start),
		.world_row        (world_row),
		.span_length      (span_length),
		.scroll_x         (scroll_x),
		.scroll_y         (scroll_y),
		.last             (last)
	);

endmodule

[sv/tsrp_mod.sv]
// Iterative signed modulo unit: one quotient bit per cycle, then a sign fix,
// giving a result in [0, modulus). Depends on tsrp_pkg.
module tsrp_mod import tsrp_pkg::*; #(
	parameter int SizeW = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COORD_W-1:0] value,
	input  logic [SizeW-1:0]          modulus,
	output logic                      done,
	output logic [SizeW-1:0]          result
);

	localparam int CntW = $clog2(COORD_W + 1);

	logic [COORD_W-1:0] mag_q;
	logic               neg_q;
	logic [SizeW-1:0]   r_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [SizeW:0]     sh;
	logic [SizeW:0]     sub;
	logic [SizeW-1:0]   fix;
	logic               last_step;

	always_comb begin
		sh        = {r_q, mag_q[COORD_W-1]};
		sub       = sh - {1'b0, modulus};
		fix       = modulus - r_q;
		last_step = (cnt_q == CntW'(COORD_W));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last_step) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= value[COORD_W-1] ? COORD_W'(-value) : COORD_W'(value);
			neg_q <= value[COORD_W-1];
			r_q   <= '0;
		end else if (busy_q) begin
			if (!last_step) begin
				r_q   <= (sh >= {1'b0, modulus}) ? SizeW'(sub) : SizeW'(sh);
				mag_q <= mag_q << 1;
			end else if (neg_q && r_q != '0) begin
				r_q <= fix;
			end
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

[sv/tsrp_datapath.sv]
// Datapath: clamp and tile registers, previous tile, move decision, area
// span counters, two modulo units and the output word register.
// Depends on tsrp_pkg and tsrp_mod.
module tsrp_datapath import tsrp_pkg::*; #(
	parameter int MaxMapTiles = MAX_MAP_TILES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tsrp_cmd_t               cmd,
	output tsrp_stat_t              stat,
	input  logic [SIZE_CFG_W-1:0]   map_width_tiles,
	input  logic [SIZE_CFG_W-1:0]   map_height_tiles,
	input  logic                    wrap_enable,
	input  logic [VIEW_W-1:0]       view_width_px,
	input  logic [VIEW_W-1:0]       view_height_px,
	input  logic signed [PX_W-1:0]  view_x_px,
	input  logic signed [PX_W-1:0]  view_y_px,
	input  logic                    force_refill,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [RING_W-1:0]       map_row,
	output logic [RING_W-1:0]       map_col_start,
	output logic [WORLD_W-1:0]      world_x_start,
	output logic [WORLD_W-1:0]      world_row,
	output logic [LEN_W-1:0]        span_length,
	output logic signed [PX_W-1:0]  scroll_x,
	output logic signed [PX_W-1:0]  scroll_y,
	output logic                    last
);

	localparam int SizeW = $clog2(MaxMapTiles + 1);
	localparam int ExtW  = (SizeW > SIZE_CFG_W) ? SizeW : SIZE_CFG_W;
	localparam int ClW   = (SizeW + 4 > PX_W + 1) ? SizeW + 4 : PX_W + 1;

	function automatic logic [SizeW-1:0] eff_size(input logic [SIZE_CFG_W-1:0] v);
		logic [ExtW-1:0] e;
		e = ExtW'(v);
		if (v == '0)
			return SizeW'(1);
		if (e > ExtW'(MaxMapTiles))
			return SizeW'(MaxMapTiles);
		return SizeW'(e);
	endfunction

	function automatic logic signed [PX_W-1:0] clamp_px(
		input logic signed [PX_W-1:0] p,
		input logic [SizeW-1:0]       sz,
		input logic [VIEW_W-1:0]      vw
	);
		logic signed [ClW-1:0] lim;
		logic signed [ClW-1:0] v;
		lim = $signed(ClW'({sz, {TILE_SHIFT{1'b0}}})) - $signed(ClW'(vw));
		v   = ClW'(p);
		if (v < 0)
			v = '0;
		if (v > lim)
			v = lim;
		return PX_W'(v);
	endfunction

	logic [SizeW-1:0]         w_eff;
	logic [SizeW-1:0]         h_eff;
	logic signed [PX_W-1:0]   xc;
	logic signed [PX_W-1:0]   yc;

	logic signed [PX_W-1:0]   sx_q;
	logic signed [PX_W-1:0]   sy_q;
	logic signed [TILE_W-1:0] tx_q;
	logic signed [TILE_W-1:0] ty_q;
	logic                     force_q;
	logic signed [TILE_W-1:0] prev_x_q;
	logic signed [TILE_W-1:0] prev_y_q;

	logic signed [COORD_W-1:0] dx;
	logic signed [COORD_W-1:0] dy;
	logic [COORD_W-1:0]        ax;
	logic [COORD_W-1:0]        ay;
	logic [2*LEN_W-1:0]        prod;
	logic                      big_move;
	logic                      full_move;

	logic                     nochange_q;
	logic                     full_q;
	logic                     hor_q;
	logic                     ver_q;
	logic                     hpos_q;
	logic                     vpos_q;
	logic [LEN_W-1:0]         ax_q;
	logic [LEN_W-1:0]         ay_q;

	logic signed [COORD_W-1:0] x0;
	logic signed [COORD_W-1:0] y0;
	logic [LEN_W-1:0]          rows0;
	logic [LEN_W-1:0]          len0;

	logic [RING_W-1:0]        col_q;
	logic [RING_W-1:0]        row_q;
	logic [LEN_W-1:0]         rows_left_q;
	logic [LEN_W-1:0]         len_q;
	logic [SizeW-1:0]         wx_q;
	logic [SizeW-1:0]         wy_q;
	logic [SizeW:0]           wy_inc;

	logic                     done_x;
	logic                     done_y;
	logic [SizeW-1:0]         mod_x;
	logic [SizeW-1:0]         mod_y;

	logic                     out_valid_q;
	logic [RING_W-1:0]        map_row_q;
	logic [RING_W-1:0]        map_col_q;
	logic [WORLD_W-1:0]       world_x_q;
	logic [WORLD_W-1:0]       world_row_q;
	logic [LEN_W-1:0]         span_len_q;
	logic signed [PX_W-1:0]   scroll_x_q;
	logic signed [PX_W-1:0]   scroll_y_q;
	logic                     last_q;
	logic                     out_free;

	always_comb begin
		w_eff = eff_size(map_width_tiles);
		h_eff = eff_size(map_height_tiles);
		xc    = wrap_enable ? view_x_px : clamp_px(view_x_px, w_eff, view_width_px);
		yc    = wrap_enable ? view_y_px : clamp_px(view_y_px, h_eff, view_height_px);
	end

	// move decision
	always_comb begin
		dx        = COORD_W'(tx_q) - COORD_W'(prev_x_q);
		dy        = COORD_W'(ty_q) - COORD_W'(prev_y_q);
		ax        = dx[COORD_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
		ay        = dy[COORD_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
		prod      = ax[LEN_W-1:0] * ay[LEN_W-1:0];
		big_move  = (ax > COORD_W'(SPAN_COLS)) || (ay > COORD_W'(SPAN_ROWS));
		full_move = force_q || big_move || (prod > (2*LEN_W)'(OVERLAP_LIMIT));
	end

	// area setup
	always_comb begin
		x0    = COORD_W'(tx_q);
		y0    = COORD_W'(ty_q);
		rows0 = LEN_W'(SPAN_ROWS + 1);
		len0  = LEN_W'(SPAN_COLS + 1);
		case (cmd.area)
			AREA_HORZ: begin
				if (hpos_q)
					x0 = COORD_W'(tx_q) + COORD_W'(SPAN_COLS + 1) - COORD_W'(ax_q);
				len0 = ax_q;
			end
			AREA_VERT: begin
				if (vpos_q)
					y0 = COORD_W'(ty_q) + COORD_W'(SPAN_ROWS + 1) - COORD_W'(ay_q);
				rows0 = ay_q;
			end
			default: begin
			end
		endcase
	end

	tsrp_mod #(.SizeW(SizeW)) u_mod_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.area_start),
		.value   (x0),
		.modulus (w_eff),
		.done    (done_x),
		.result  (mod_x)
	);

	tsrp_mod #(.SizeW(SizeW)) u_mod_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.area_start),
		.value   (y0),
		.modulus (h_eff),
		.done    (done_y),
		.result  (mod_y)
	);

	assign wy_inc   = {1'b0, wy_q} + 1'b1;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '1;
			prev_y_q    <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_prev) begin
				prev_x_q <= '1;
				prev_y_q <= '1;
			end else if (cmd.plan) begin
				prev_x_q <= tx_q;
				prev_y_q <= ty_q;
			end
			if (cmd.emit || cmd.emit_none)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q    <= xc;
			sy_q    <= yc;
			tx_q    <= xc[PX_W-1:TILE_SHIFT];
			ty_q    <= yc[PX_W-1:TILE_SHIFT];
			force_q <= force_refill;
		end
		if (cmd.plan) begin
			nochange_q <= (dx == '0) && (dy == '0) && !force_q;
			full_q     <= full_move;
			hor_q      <= (dx != '0);
			ver_q      <= (dy != '0);
			hpos_q     <= !dx[COORD_W-1];
			vpos_q     <= !dy[COORD_W-1];
			ax_q       <= ax[LEN_W-1:0];
			ay_q       <= ay[LEN_W-1:0];
		end
		if (cmd.area_start) begin
			col_q       <= x0[RING_W-1:0];
			row_q       <= y0[RING_W-1:0];
			rows_left_q <= rows0;
			len_q       <= len0;
		end
		if (cmd.take_mod) begin
			wx_q <= mod_x;
			wy_q <= mod_y;
		end
		if (cmd.emit) begin
			row_q       <= row_q + 1'b1;
			rows_left_q <= rows_left_q - 1'b1;
			wy_q        <= (wy_inc == {1'b0, h_eff}) ? '0 : SizeW'(wy_inc);
			map_row_q   <= row_q;
			map_col_q   <= col_q;
			world_x_q   <= WORLD_W'(wx_q);
			world_row_q <= WORLD_W'(wy_q);
			span_len_q  <= len_q;
			scroll_x_q  <= sx_q;
			scroll_y_q  <= sy_q;
			last_q      <= cmd.last;
		end else if (cmd.emit_none) begin
			map_row_q   <= '0;
			map_col_q   <= '0;
			world_x_q   <= '0;
			world_row_q <= '0;
			span_len_q  <= '0;
			scroll_x_q  <= sx_q;
			scroll_y_q  <= sy_q;
			last_q      <= 1'b1;
		end
	end

	always_comb begin
		stat.nochange  = nochange_q;
		stat.full      = full_q;
		stat.hor_strip = hor_q;
		stat.ver_strip = ver_q;
		stat.mods_done = done_x && done_y;
		stat.rows_last = (rows_left_q == LEN_W'(1));
		stat.out_free  = out_free;
	end

	assign out_valid     = out_valid_q;
	assign map_row       = map_row_q;
	assign map_col_start = map_col_q;
	assign world_x_start = world_x_q;
	assign world_row     = world_row_q;
	assign span_length   = span_len_q;
	assign scroll_x      = scroll_x_q;
	assign scroll_y      = scroll_y_q;
	assign last          = last_q;

	a_emit_has_rows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> rows_left_q != '0)
		else $error("span emitted with no rows left");

	a_mod_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_mod |-> (done_x && done_y))
		else $error("modulo result taken before both units finished");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_none) |-> (!out_valid_q || out_ready))
		else $error("output word overwritten while still pending");

endmodule

[sv/tsrp_ctrl.sv]
// Controller: sequences load, plan, decide, area setup, modulo wait, span
// emission and the no-change word. Depends on tsrp_pkg.
module tsrp_ctrl import tsrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       operation,
	output logic       in_ready,
	output tsrp_cmd_t  cmd,
	input  tsrp_stat_t stat
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PLAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_AREA   = 3'd3;
	localparam logic [2:0] S_MOD    = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_NONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] area_q;
	logic [1:0] area_d;
	logic       final_area;

	always_comb begin
		cmd        = '0;
		cmd.area   = area_q;
		state_d    = state_q;
		area_d     = area_q;
		in_ready   = (state_q == S_IDLE);
		final_area = (area_q != AREA_HORZ) || !stat.ver_strip;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation) begin
						cmd.load = 1'b1;
						state_d  = S_PLAN;
					end else begin
						cmd.clear_prev = 1'b1;
					end
				end
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.nochange) begin
					state_d = S_NONE;
				end else begin
					state_d = S_AREA;
					if (stat.full)
						area_d = AREA_FULL;
					else if (stat.hor_strip)
						area_d = AREA_HORZ;
					else
						area_d = AREA_VERT;
				end
			end
			S_AREA: begin
				cmd.area_start = 1'b1;
				state_d        = S_MOD;
			end
			S_MOD: begin
				if (stat.mods_done) begin
					cmd.take_mod = 1'b1;
					state_d      = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = final_area && stat.rows_last;
					if (stat.rows_last) begin
						if (final_area) begin
							state_d = S_IDLE;
						end else begin
							area_d  = AREA_VERT;
							state_d = S_AREA;
						end
					end
				end
			end
			S_NONE: begin
				if (stat.out_free) begin
					cmd.emit_none = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			area_q  <= AREA_FULL;
		end else begin
			state_q <= state_d;
			area_q  <= area_d;
		end
	end

	a_scroll_starts_plan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation) |=> state_q == S_PLAN)
		else $error("scroll word accepted without entering plan");

endmodule
